@@ rtl/trf_pkg.sv @@
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants for the timed release FIFO
// Operation codes, request/result payload structs and register map.
// ----------------------------------------------------------------------------
package trf_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_FETCH  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  // queue depth is tied to the occupancy field width below
  localparam int QUEUE_DEPTH = 16;

  localparam int DATA_W  = 64;
  localparam int TIME_W  = 64;
  localparam int DELAY_W = 32;
  localparam int OCC_W   = 5;

  // APB map: one 32-bit register at byte address 0
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DELAY_TICKS = 1'b0;

  typedef struct packed {
    opcode_t             opcode;
    logic [DATA_W-1:0]   data_in;
  } cmd_t;

  typedef struct packed {
    logic                fetched;
    logic [DATA_W-1:0]   data_out;
    logic [OCC_W-1:0]    occupancy;
    logic                overflow;
  } res_t;

endpackage

@@ rtl/timed_release_fifo.sv @@
// ----------------------------------------------------------------------------
// timed_release_fifo: FIFO whose entries release after a configured delay
// Top level: request register, queue execute, result register, APB register.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one request per operation:
//   tick, insert, fetch or clear. Every request yields exactly one result on
//   the res channel (res_valid/res_stall/res) with fetch outcome, data,
//   occupancy and overflow flag.
//   Throughput: one request per cycle while res_stall is low; each operation
//   is a pointer or time counter update, one 65-bit add and compare against
//   the time counter, and one write or registered read of the entry memories.
//   When the receiver holds res_stall, the result register holds and the
//   request register fills; cmd_stall rises once both are occupied.
//   delay_ticks sits at APB byte address 0; write it only while idle.
//   Reset (rst, synchronous) empties the queue, zeroes the time counter and
//   delay_ticks, and drops any request or result in flight. No clearing pass
//   is needed; unwritten entries are never released.
// ----------------------------------------------------------------------------
module timed_release_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  trf_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_stall,
  output trf_pkg::res_t                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trf_pkg::PADDR_W-1:0]   paddr,
  input  logic [trf_pkg::PDATA_W-1:0]   pwdata,
  output logic [trf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  trf_pkg::cmd_t                 cmd_q;
  logic                          cmd_q_valid;
  trf_pkg::res_t                 res_next;
  logic                          exec;
  logic                          cmd_take;
  logic [trf_pkg::DELAY_W-1:0]   delay_ticks;

  // execute when the result register is free or drains this cycle
  assign exec      = cmd_q_valid && (!res_valid || !res_stall);
  assign cmd_stall = cmd_q_valid && !exec;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (cmd_take) begin
      cmd_q_valid <= 1'b1;
    end else if (exec) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res <= res_next;
    end
  end

  trf_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .delay_ticks (delay_ticks)
  );

  trf_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .exec        (exec),
    .cmd         (cmd_q),
    .delay_ticks (delay_ticks),
    .res         (res_next)
  );

endmodule

@@ rtl/trf_apb_regs.sv @@
// ----------------------------------------------------------------------------
// trf_apb_regs: APB configuration register
// Holds delay_ticks; zero-wait-state writes and reads.
// ----------------------------------------------------------------------------
module trf_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trf_pkg::PADDR_W-1:0]   paddr,
  input  logic [trf_pkg::PDATA_W-1:0]   pwdata,
  output logic [trf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [trf_pkg::DELAY_W-1:0]   delay_ticks
);

  logic wr_en;
  logic sel_delay;

  // register index is the word address
  assign sel_delay = (paddr[2] == trf_pkg::REG_DELAY_TICKS);
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= '0;
    end else if (wr_en && sel_delay) begin
      delay_ticks <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_delay) begin
      prdata = delay_ticks;
    end
  end

endmodule

@@ rtl/trf_queue.sv @@
// ----------------------------------------------------------------------------
// trf_queue: stamped FIFO storage and operation execute
// Time counter, pointers, entry memories and the release test.
// ----------------------------------------------------------------------------
module trf_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          exec,
  input  trf_pkg::cmd_t                 cmd,
  input  logic [trf_pkg::DELAY_W-1:0]   delay_ticks,
  output trf_pkg::res_t                 res
);

  localparam int AW = (trf_pkg::QUEUE_DEPTH > 1) ? $clog2(trf_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(trf_pkg::QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(trf_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(trf_pkg::QUEUE_DEPTH);

  logic [trf_pkg::TIME_W-1:0] now_count, now_count_next;
  logic [AW-1:0]              head_ptr, head_ptr_next;
  logic [AW-1:0]              tail_ptr, tail_ptr_next;
  logic [CW-1:0]              entry_count, entry_count_next;

  logic [trf_pkg::TIME_W-1:0] stamp_store [trf_pkg::QUEUE_DEPTH];
  logic [trf_pkg::DATA_W-1:0] value_store [trf_pkg::QUEUE_DEPTH];

  // registered copy of the entry at head_ptr
  logic [trf_pkg::TIME_W-1:0] head_stamp;
  logic [trf_pkg::DATA_W-1:0] head_value;

  logic                       full, empty, head_ready;
  logic                       do_insert, do_fetch, ovf;
  logic [trf_pkg::TIME_W:0]   release_sum;

  assign full  = (entry_count == FULL_CNT);
  assign empty = (entry_count == '0);

  // 65-bit sum: a carry out means the entry never releases
  assign release_sum = {1'b0, head_stamp} + {{(trf_pkg::TIME_W-trf_pkg::DELAY_W+1){1'b0}},
                                             delay_ticks};
  assign head_ready  = (release_sum <= {1'b0, now_count});

  assign do_insert = exec && (cmd.opcode == trf_pkg::OP_INSERT) && !full;
  assign do_fetch  = exec && (cmd.opcode == trf_pkg::OP_FETCH) && !empty && head_ready;
  assign ovf       = exec && (cmd.opcode == trf_pkg::OP_INSERT) && full;

  always_comb begin
    now_count_next   = now_count;
    head_ptr_next    = head_ptr;
    tail_ptr_next    = tail_ptr;
    entry_count_next = entry_count;
    if (exec) begin
      case (cmd.opcode)
        trf_pkg::OP_TICK: begin
          now_count_next = now_count + 1'b1;
        end
        trf_pkg::OP_INSERT: begin
          if (do_insert) begin
            tail_ptr_next    = (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + 1'b1;
            entry_count_next = entry_count + 1'b1;
          end
        end
        trf_pkg::OP_FETCH: begin
          if (do_fetch) begin
            head_ptr_next    = (head_ptr == LAST_SLOT) ? '0 : head_ptr + 1'b1;
            entry_count_next = entry_count - 1'b1;
          end
        end
        trf_pkg::OP_CLEAR: begin
          head_ptr_next    = '0;
          tail_ptr_next    = '0;
          entry_count_next = '0;
        end
        default: begin
          now_count_next = now_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_count   <= '0;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      entry_count <= '0;
    end else begin
      now_count   <= now_count_next;
      head_ptr    <= head_ptr_next;
      tail_ptr    <= tail_ptr_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      stamp_store[tail_ptr] <= now_count;
      value_store[tail_ptr] <= cmd.data_in;
    end
  end

  // head prefetch: read the next head every cycle, bypass a write to that slot
  always_ff @(posedge clk) begin
    if (do_insert && (tail_ptr == head_ptr_next)) begin
      head_stamp <= now_count;
      head_value <= cmd.data_in;
    end else begin
      head_stamp <= stamp_store[head_ptr_next];
      head_value <= value_store[head_ptr_next];
    end
  end

  always_comb begin
    res.fetched   = do_fetch;
    res.data_out  = do_fetch ? head_value : '0;
    res.occupancy = trf_pkg::OCC_W'(entry_count_next);
    res.overflow  = ovf;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count above depth");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0 || entry_count == FULL_CNT) |-> head_ptr == tail_ptr)
    else $error("pointers disagree with entry count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (exec && cmd.opcode == trf_pkg::OP_CLEAR) |=>
      (entry_count == '0 && head_ptr == '0 && tail_ptr == '0))
    else $error("clear did not empty the queue");

  a_tick: assert property (@(posedge clk) disable iff (rst)
    (exec && cmd.opcode == trf_pkg::OP_TICK) |=> now_count == $past(now_count) + 1'b1)
    else $error("tick did not advance time");

  a_fetch_ready: assert property (@(posedge clk) disable iff (rst)
    do_fetch |-> (!release_sum[trf_pkg::TIME_W] && !empty))
    else $error("fetch released an entry that was not due");

endmodule
